// ===== design/shsl_pkg.sv =====
package shsl_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int HOUR_SLOTS      = 24;
    localparam int SUB_SLOTS       = 6;
    localparam int RECENT_HOURS    = 12;
    localparam int MINUTES_PER_SUB = 10;

    localparam int CNT_BITS      = $clog2(HOUR_SLOTS + 1);
    localparam int SUM_BITS      = SAMPLE_BITS + CNT_BITS;
    localparam int HOUR_IDX_BITS = $clog2(HOUR_SLOTS);
    localparam int SUB_IDX_BITS  = $clog2(SUB_SLOTS);
    localparam int STEP_BITS     = $clog2(SAMPLE_BITS + 1);

    localparam int HOUR_FIELD_BITS   = 5;
    localparam int MINUTE_FIELD_BITS = 6;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;

    typedef struct packed {
        sample_t                      sample;
        logic                         latch_sample;
        logic [HOUR_FIELD_BITS-1:0]   clock_hour;
        logic [MINUTE_FIELD_BITS-1:0] clock_minute;
        logic [HOUR_FIELD_BITS-1:0]   query_hour;
    } in_req_t;

    typedef struct packed {
        sample_t current_value;
        sample_t hour_mean;
        sample_t mean_12h;
        sample_t mean_24h;
        sample_t min_24h;
        sample_t max_24h;
        logic    data_missing;
        sample_t queried_hour_value;
        logic    queried_hour_valid;
    } out_req_t;

    typedef struct packed {
        logic                     sub_we;
        logic [SUB_IDX_BITS-1:0]  sub_idx;
        logic                     hour_we;
        logic [HOUR_IDX_BITS-1:0] hour_idx;
        sample_t                  data;
    } slot_wr_t;

    typedef struct packed {
        sample_t sub_data;
        logic    sub_valid;
        sample_t hour_data;
        logic    hour_valid;
    } slot_rd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUB_WALK,
        ST_SUB_DIV,
        ST_SUB_WAIT,
        ST_HOUR_WR,
        ST_HOUR_WALK,
        ST_DIV12,
        ST_WAIT12,
        ST_DIV24,
        ST_WAIT24,
        ST_EMIT
    } state_t;

endpackage

// ===== design/shsl_div.sv =====
module shsl_div import shsl_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  sum_t    dividend,
    input  cnt_t    divisor,
    output logic    done,
    output sample_t quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    cnt_t                   divisor_reg, divisor_next;
    cnt_t                   rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;

    logic [SUM_BITS-1:0]    mag;
    logic [CNT_BITS:0]      trial;

    always_comb begin
        mag          = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
        trial        = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        busy_next    = busy_reg;
        done_next    = 1'b0;
        neg_next     = neg_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        if (start) begin
            busy_next    = 1'b1;
            neg_next     = dividend[SUM_BITS-1];
            divisor_next = divisor;
            // |dividend| < divisor * 2^SAMPLE_BITS, so the high part starts below divisor
            rem_next     = mag[SUM_BITS-1:SAMPLE_BITS];
            quo_next     = mag[SAMPLE_BITS-1:0];
            step_next    = STEP_BITS'(SAMPLE_BITS);
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor_reg}) begin
                rem_next = CNT_BITS'(trial - {1'b0, divisor_reg});
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_BITS-1:0];
                quo_next = {quo_reg[SAMPLE_BITS-2:0], 1'b0};
            end
            step_next = step_reg - STEP_BITS'(1);
            if (step_reg == STEP_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        neg_reg     <= neg_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        step_reg    <= step_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? sample_t'(-quo_reg) : sample_t'(quo_reg);

endmodule

// ===== design/shsl_slots.sv =====
module shsl_slots import shsl_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  slot_wr_t                 wr,
    input  logic [SUB_IDX_BITS-1:0]  rd_sub_idx,
    input  logic [HOUR_IDX_BITS-1:0] rd_hour_idx,
    output slot_rd_t                 rd
);

    sample_t                 sub_mem [SUB_SLOTS];
    sample_t                 hour_mem [HOUR_SLOTS];
    logic [SUB_SLOTS-1:0]    sub_valid_reg;
    logic [HOUR_SLOTS-1:0]   hour_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_valid_reg  <= '0;
            hour_valid_reg <= '0;
        end else begin
            if (wr.sub_we) begin
                sub_valid_reg[wr.sub_idx] <= 1'b1;
            end
            if (wr.hour_we) begin
                hour_valid_reg[wr.hour_idx] <= 1'b1;
            end
        end
        if (wr.sub_we) begin
            sub_mem[wr.sub_idx] <= wr.data;
        end
        if (wr.hour_we) begin
            hour_mem[wr.hour_idx] <= wr.data;
        end
    end

    always_comb begin
        rd.sub_data   = sub_mem[rd_sub_idx];
        rd.sub_valid  = sub_valid_reg[rd_sub_idx];
        rd.hour_data  = hour_mem[rd_hour_idx];
        rd.hour_valid = hour_valid_reg[rd_hour_idx];
    end

endmodule

// ===== design/sensor_hourly_statistics_logger_top.sv =====
// Hourly statistics logger for one sensor channel. Each request may latch a new
// current value, fills a ten-minute slot on minutes 0, 10, ..., 50 and an hour slot
// at minute zero of hours 0 to 23, then returns the current value, the hour, last-twelve-hour and
// 24-hour means (truncated toward zero, the current value when no slot holds data),
// min and max over all filled slots and the current value, a missing-data flag and one hour slot read back.
// The block takes one request at a time: 6 + 24 slot reads plus up to three
// divisions, fewer divisions when a mean has no data. The slot walks read one slot per
// cycle and the means go through one shared restoring divider, one quotient bit per
// cycle. A finished result waits in the output register while the next request is
// taken. No clearing pass is needed after reset.
module sensor_hourly_statistics_logger_top import shsl_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_req_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output out_req_t m_data
);

    state_t                     state_reg, state_next;
    sample_t                    latched_reg, latched_next;
    logic [HOUR_FIELD_BITS-1:0] hr_reg, hr_next;
    logic [HOUR_FIELD_BITS-1:0] qh_reg, qh_next;
    logic                       hwr_reg, hwr_next;
    logic [HOUR_IDX_BITS-1:0]   idx_reg, idx_next;
    sum_t                       sum_reg, sum_next;
    cnt_t                       cnt_reg, cnt_next;
    sum_t                       sum12_reg, sum12_next;
    cnt_t                       cnt12_reg, cnt12_next;
    sample_t                    lo_reg, lo_next;
    sample_t                    hi_reg, hi_next;
    logic                       missing_reg, missing_next;
    sample_t                    hmean_reg, hmean_next;
    sample_t                    m12_reg, m12_next;
    sample_t                    m24_reg, m24_next;
    sample_t                    qval_reg, qval_next;
    logic                       qvalid_reg, qvalid_next;
    out_req_t                   out_reg, out_next;
    logic                       m_valid_reg, m_valid_next;

    slot_wr_t                   wr;
    slot_rd_t                   rd;
    logic                       div_start;
    sum_t                       div_dividend;
    cnt_t                       div_divisor;
    logic                       div_done;
    sample_t                    div_quotient;

    logic                       sub_hit;
    logic [SUB_IDX_BITS-1:0]    sub_hit_idx;
    logic [HOUR_IDX_BITS-1:0]   win_start;
    logic [HOUR_IDX_BITS:0]     win_dist;

    shsl_slots u_slots (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .rd_sub_idx  (idx_reg[SUB_IDX_BITS-1:0]),
        .rd_hour_idx (idx_reg),
        .rd          (rd)
    );

    shsl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb begin
        sub_hit     = 1'b0;
        sub_hit_idx = '0;
        for (int k = 0; k < SUB_SLOTS; k++) begin
            if (s_data.clock_minute == MINUTE_FIELD_BITS'(k * MINUTES_PER_SUB)) begin
                sub_hit     = 1'b1;
                sub_hit_idx = SUB_IDX_BITS'(k);
            end
        end
    end

    always_comb begin
        if (hr_reg >= HOUR_FIELD_BITS'(HOUR_SLOTS)) begin
            win_start = HOUR_IDX_BITS'(hr_reg - HOUR_FIELD_BITS'(HOUR_SLOTS));
        end else begin
            win_start = HOUR_IDX_BITS'(hr_reg);
        end
        if (win_start >= idx_reg) begin
            win_dist = (HOUR_IDX_BITS+1)'(win_start - idx_reg);
        end else begin
            win_dist = (HOUR_IDX_BITS+1)'({1'b0, win_start} + (HOUR_IDX_BITS+1)'(HOUR_SLOTS)
                       - {1'b0, idx_reg});
        end
    end

    always_comb begin
        state_next   = state_reg;
        latched_next = latched_reg;
        hr_next      = hr_reg;
        qh_next      = qh_reg;
        hwr_next     = hwr_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        sum12_next   = sum12_reg;
        cnt12_next   = cnt12_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        missing_next = missing_reg;
        hmean_next   = hmean_reg;
        m12_next     = m12_reg;
        m24_next     = m24_reg;
        qval_next    = qval_reg;
        qvalid_next  = qvalid_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        s_ready      = 1'b0;
        wr           = '0;
        div_start    = 1'b0;
        div_dividend = sum_reg;
        div_divisor  = cnt_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_data.latch_sample) begin
                        latched_next = s_data.sample;
                    end
                    hr_next    = s_data.clock_hour;
                    qh_next    = s_data.query_hour;
                    hwr_next   = (s_data.clock_minute == '0) &&
                                 (s_data.clock_hour < HOUR_FIELD_BITS'(HOUR_SLOTS));
                    wr.sub_we  = sub_hit;
                    wr.sub_idx = sub_hit_idx;
                    wr.data    = latched_next;
                    idx_next   = '0;
                    sum_next   = '0;
                    cnt_next   = '0;
                    lo_next    = latched_next;
                    hi_next    = latched_next;
                    state_next = ST_SUB_WALK;
                end
            end
            ST_SUB_WALK: begin
                if (rd.sub_valid) begin
                    sum_next = sum_reg + SUM_BITS'(rd.sub_data);
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    if (rd.sub_data < lo_reg) lo_next = rd.sub_data;
                    if (rd.sub_data > hi_reg) hi_next = rd.sub_data;
                end
                idx_next = idx_reg + HOUR_IDX_BITS'(1);
                if (idx_reg == HOUR_IDX_BITS'(SUB_SLOTS - 1)) begin
                    state_next = ST_SUB_DIV;
                end
            end
            ST_SUB_DIV: begin
                if (cnt_reg == '0) begin
                    hmean_next = latched_reg;
                    state_next = ST_HOUR_WR;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_SUB_WAIT;
                end
            end
            ST_SUB_WAIT: begin
                if (div_done) begin
                    hmean_next = div_quotient;
                    state_next = ST_HOUR_WR;
                end
            end
            ST_HOUR_WR: begin
                wr.hour_we   = hwr_reg;
                wr.hour_idx  = HOUR_IDX_BITS'(hr_reg);
                wr.data      = hmean_reg;
                idx_next     = '0;
                sum_next     = '0;
                cnt_next     = '0;
                sum12_next   = '0;
                cnt12_next   = '0;
                missing_next = 1'b0;
                qval_next    = '0;
                qvalid_next  = 1'b0;
                state_next   = ST_HOUR_WALK;
            end
            ST_HOUR_WALK: begin
                if (rd.hour_valid) begin
                    sum_next = sum_reg + SUM_BITS'(rd.hour_data);
                    cnt_next = cnt_reg + CNT_BITS'(1);
                    if (rd.hour_data < lo_reg) lo_next = rd.hour_data;
                    if (rd.hour_data > hi_reg) hi_next = rd.hour_data;
                    if (win_dist < (HOUR_IDX_BITS+1)'(RECENT_HOURS)) begin
                        sum12_next = sum12_reg + SUM_BITS'(rd.hour_data);
                        cnt12_next = cnt12_reg + CNT_BITS'(1);
                    end
                    if (HOUR_FIELD_BITS'(idx_reg) == qh_reg) begin
                        qval_next   = rd.hour_data;
                        qvalid_next = 1'b1;
                    end
                end else begin
                    missing_next = 1'b1;
                end
                idx_next = idx_reg + HOUR_IDX_BITS'(1);
                if (idx_reg == HOUR_IDX_BITS'(HOUR_SLOTS - 1)) begin
                    state_next = ST_DIV12;
                end
            end
            ST_DIV12: begin
                div_dividend = sum12_reg;
                div_divisor  = cnt12_reg;
                if (cnt12_reg == '0) begin
                    m12_next   = latched_reg;
                    state_next = ST_DIV24;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT12;
                end
            end
            ST_WAIT12: begin
                if (div_done) begin
                    m12_next   = div_quotient;
                    state_next = ST_DIV24;
                end
            end
            ST_DIV24: begin
                if (cnt_reg == '0) begin
                    m24_next   = latched_reg;
                    state_next = ST_EMIT;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_WAIT24;
                end
            end
            ST_WAIT24: begin
                if (div_done) begin
                    m24_next   = div_quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.current_value      = latched_reg;
                    out_next.hour_mean          = hmean_reg;
                    out_next.mean_12h           = m12_reg;
                    out_next.mean_24h           = m24_reg;
                    out_next.min_24h            = lo_reg;
                    out_next.max_24h            = hi_reg;
                    out_next.data_missing       = missing_reg;
                    out_next.queried_hour_value = qval_reg;
                    out_next.queried_hour_valid = qvalid_reg;
                    m_valid_next                = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            latched_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            latched_reg <= latched_next;
            m_valid_reg <= m_valid_next;
        end
        hr_reg      <= hr_next;
        qh_reg      <= qh_next;
        hwr_reg     <= hwr_next;
        idx_reg     <= idx_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        sum12_reg   <= sum12_next;
        cnt12_reg   <= cnt12_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        missing_reg <= missing_next;
        hmean_reg   <= hmean_next;
        m12_reg     <= m12_next;
        m24_reg     <= m24_next;
        qval_reg    <= qval_next;
        qvalid_reg  <= qvalid_next;
        out_reg     <= out_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== test/tb.sv =====
module tb;
    import shsl_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 200;
    localparam int IDLE_PCT    = 38;
    localparam int MAX_REPORTS = 10;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_req_t m_data;

    sensor_hourly_statistics_logger_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // shadow copy of the logger state
    sample_t cur_value;
    sample_t tenmin_val [SUB_SLOTS];
    bit      tenmin_ok  [SUB_SLOTS];
    sample_t hour_val   [HOUR_SLOTS];
    bit      hour_ok    [HOUR_SLOTS];

    out_req_t    expected_stats[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    bit          no_idle = 1'b0;

    // walking wall clock for well-formed sequences
    int walk_hour = 0;
    int walk_minute = 0;

    function automatic sample_t mean_or_current(longint sum, int n);
        if (n == 0) return cur_value;
        return sample_t'(sum / n);
    endfunction

    function automatic sample_t tenmin_mean();
        longint sum;
        int     n;
        sum = 0;
        n = 0;
        for (int i = 0; i < SUB_SLOTS; i++) begin
            if (tenmin_ok[i]) begin
                sum += tenmin_val[i];
                n++;
            end
        end
        return mean_or_current(sum, n);
    endfunction

    function automatic out_req_t update_stats(in_req_t r);
        out_req_t o;
        longint   sum;
        int       n;
        int       start;
        int       idx;
        sample_t  lo;
        sample_t  hi;
        bit       missing;

        if (r.latch_sample) cur_value = r.sample;
        if (r.clock_minute < SUB_SLOTS * MINUTES_PER_SUB &&
            r.clock_minute % MINUTES_PER_SUB == 0) begin
            tenmin_val[r.clock_minute / MINUTES_PER_SUB] = cur_value;
            tenmin_ok[r.clock_minute / MINUTES_PER_SUB] = 1'b1;
        end
        if (r.clock_minute == 0 && r.clock_hour < HOUR_SLOTS) begin
            hour_val[r.clock_hour] = tenmin_mean();
            hour_ok[r.clock_hour] = 1'b1;
        end

        o.current_value = cur_value;
        o.hour_mean = tenmin_mean();

        start = r.clock_hour % HOUR_SLOTS;
        sum = 0;
        n = 0;
        for (int i = 0; i < RECENT_HOURS; i++) begin
            idx = (start + HOUR_SLOTS - i) % HOUR_SLOTS;
            if (hour_ok[idx]) begin
                sum += hour_val[idx];
                n++;
            end
        end
        o.mean_12h = mean_or_current(sum, n);

        sum = 0;
        n = 0;
        lo = cur_value;
        hi = cur_value;
        missing = 1'b0;
        for (int i = 0; i < HOUR_SLOTS; i++) begin
            if (hour_ok[i]) begin
                sum += hour_val[i];
                n++;
                if (hour_val[i] < lo) lo = hour_val[i];
                if (hour_val[i] > hi) hi = hour_val[i];
            end else begin
                missing = 1'b1;
            end
        end
        for (int i = 0; i < SUB_SLOTS; i++) begin
            if (tenmin_ok[i]) begin
                if (tenmin_val[i] < lo) lo = tenmin_val[i];
                if (tenmin_val[i] > hi) hi = tenmin_val[i];
            end
        end
        o.mean_24h = mean_or_current(sum, n);
        o.min_24h = lo;
        o.max_24h = hi;
        o.data_missing = missing;

        if (r.query_hour < HOUR_SLOTS && hour_ok[r.query_hour]) begin
            o.queried_hour_value = hour_val[r.query_hour];
            o.queried_hour_valid = 1'b1;
        end else begin
            o.queried_hour_value = '0;
            o.queried_hour_valid = 1'b0;
        end
        return o;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %s: expected %0h got %0h", name, want, got);
        end
    endtask

    initial begin
        cur_value = '0;
        for (int i = 0; i < SUB_SLOTS; i++) begin
            tenmin_val[i] = '0;
            tenmin_ok[i] = 1'b0;
        end
        for (int i = 0; i < HOUR_SLOTS; i++) begin
            hour_val[i] = '0;
            hour_ok[i] = 1'b0;
        end
    end

    always @(posedge aclk) begin : result_check
        out_req_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                expected_stats.push_back(update_stats(s_data));
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result %0h", m_data);
                end else begin
                    want = expected_stats.pop_front();
                    check_field("current_value", want.current_value, m_data.current_value);
                    check_field("hour_mean", want.hour_mean, m_data.hour_mean);
                    check_field("mean_12h", want.mean_12h, m_data.mean_12h);
                    check_field("mean_24h", want.mean_24h, m_data.mean_24h);
                    check_field("min_24h", want.min_24h, m_data.min_24h);
                    check_field("max_24h", want.max_24h, m_data.max_24h);
                    check_field("data_missing", want.data_missing, m_data.data_missing);
                    check_field("queried_hour_value", want.queried_hour_value,
                                m_data.queried_hour_value);
                    check_field("queried_hour_valid", want.queried_hour_valid,
                                m_data.queried_hour_valid);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sensor_hourly_statistics_logger_top test failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

    function automatic in_req_t make_req(int smp, bit latch, int hr, int mn, int qh);
        in_req_t r;
        r.sample = sample_t'(smp);
        r.latch_sample = latch;
        r.clock_hour = hr[4:0];
        r.clock_minute = mn[5:0];
        r.query_hour = qh[4:0];
        return r;
    endfunction

    function automatic int rand_sample();
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(2) - 1;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    task automatic send_request(in_req_t r);
        @(negedge aclk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = r;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid = 1'b0;
        wait (expected_stats.size() == 0);
    endtask

    task automatic test_directed();
        send_request(make_req(0, 0, 0, 1, 5));
        send_request(make_req(32767, 1, 3, 60, 3));
        send_request(make_req(-32768, 1, 7, 63, 31));
        send_request(make_req(1234, 0, 2, 61, 24));
        send_request(make_req(-32768, 1, 0, 0, 0));
        send_request(make_req(32767, 1, 0, 10, 0));
        send_request(make_req(-1, 1, 0, 20, 0));
        send_request(make_req(1, 1, 0, 30, 0));
        send_request(make_req(555, 0, 0, 40, 0));
        send_request(make_req(12345, 1, 0, 50, 0));
        send_request(make_req(-7, 1, 0, 59, 0));
        send_request(make_req(100, 1, 24, 0, 24));
        send_request(make_req(-200, 1, 31, 5, 28));
        send_request(make_req(-7, 1, 1, 0, 1));
        send_request(make_req(-32768, 1, 23, 0, 23));
        send_request(make_req(32767, 1, 12, 0, 12));
        send_request(make_req(0, 1, 13, 9, 30));
        send_request(make_req(-3, 1, 13, 11, 13));
        send_request(make_req(-32768, 1, 11, 0, 11));
        send_request(make_req(32767, 1, 27, 62, 0));
        wait_for_drain();
    endtask

    // clock walk: mostly ten-minute steps so every hour slot gets filled
    task automatic test_clock_walk(int n_items);
        int qh;
        for (int k = 0; k < n_items; k++) begin
            if ($urandom_range(99) < 3) begin
                walk_hour = $urandom_range(HOUR_SLOTS - 1);
                walk_minute = 0;
            end else if ($urandom_range(99) < 60) begin
                walk_minute = (walk_minute / MINUTES_PER_SUB + 1) * MINUTES_PER_SUB;
            end else begin
                walk_minute += $urandom_range(9, 1);
            end
            if (walk_minute >= 60) begin
                walk_minute = 0;
                walk_hour = (walk_hour + 1) % HOUR_SLOTS;
            end
            qh = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(HOUR_SLOTS - 1);
            send_request(make_req(rand_sample(), $urandom_range(99) < 70,
                                  walk_hour, walk_minute, qh));
        end
    endtask

    task automatic test_noise(int n_items);
        for (int k = 0; k < n_items; k++)
            send_request(make_req($urandom_range(65535), $urandom_range(1),
                                  $urandom_range(31), $urandom_range(63),
                                  $urandom_range(31)));
    endtask

    task automatic test_back_to_back(int n_items);
        no_idle = 1'b1;
        test_clock_walk(n_items);
        no_idle = 1'b0;
    endtask

    task automatic test_drain_pause();
        test_clock_walk(60);
        wait_for_drain();
        test_clock_walk(60);
    endtask

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_clock_walk(700);
        test_noise(250);
        test_back_to_back(250);
        test_drain_pause();
        test_clock_walk(130);

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("sensor_hourly_statistics_logger_top test passed");
        end else begin
            $display("sensor_hourly_statistics_logger_top test failed");
        end
        $finish;
    end

endmodule
